FILE: src/cgab_pkg.sv
// Package with the constants, state type and saturation helpers of the gammatone filterbank.
`default_nettype none

package cgab_pkg;

    localparam int NUM_CH     = 32;
    localparam int MAX_DELAY  = 128;
    localparam int ORDER      = 4;
    localparam int NCOEF      = 4 * ORDER - 2;
    localparam int NB         = ORDER - 1;

    localparam int CH_W       = $clog2(NUM_CH);
    localparam int NC_W       = $clog2(NUM_CH + 1);
    localparam int FS_DEPTH   = NUM_CH * 2 * ORDER;
    localparam int FS_AW      = $clog2(FS_DEPTH);
    localparam int CF_DEPTH   = NUM_CH * NCOEF;
    localparam int CF_AW      = $clog2(CF_DEPTH);
    localparam int DI_W       = $clog2(MAX_DELAY);
    localparam int DLY_DEPTH  = NUM_CH * MAX_DELAY;
    localparam int DLY_AW     = $clog2(DLY_DEPTH);

    localparam int STATE_W    = 40;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 64;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_DELAY  = 2'd2;
    localparam logic [1:0] OP_GAIN   = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_WB,
        ST_DSET,
        ST_DLY,
        ST_DLAST,
        ST_GMUL,
        ST_GACC,
        ST_OUT
    } state_t;

    function automatic logic signed [STATE_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (&v[ACC_W-1:STATE_W-1] || ~|v[ACC_W-1:STATE_W-1])
            r = v[STATE_W-1:0];
        else if (v[ACC_W-1])
            r = {1'b1, {(STATE_W-1){1'b0}}};
        else
            r = {1'b0, {(STATE_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (&v[PROD_W-1:31] || ~|v[PROD_W-1:31])
            r = v[31:0];
        else if (v[PROD_W-1])
            r = {1'b1, {31{1'b0}}};
        else
            r = {1'b0, {31{1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/cgab_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module cgab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/complex_gammatone_analysis_bank_core.sv
// Top level of the complex fourth-order gammatone analysis filterbank.
// A sample transaction runs every active channel in turn through the shared multiplier sequence,
// plus a shift of the delay line when that channel's delay length d is nonzero.
// A result waits in the output register until taken, which stalls the channel sequence and the
// input. After reset the delay memory is cleared, all 4096 entries, with no input taken.
`default_nettype none

module complex_gammatone_analysis_bank_core
    import cgab_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // channel[5:0], coef_slot[9:6], load_value[33:10], sample[49:34], zero fill
    input  wire logic [55:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_channel[5:0], real_part[37:6], imag_part[69:38], zero fill
    output logic [71:0]      m_tdata,
    output logic             m_tlast
);

    state_t state_reg, state_next;

    logic [6:0]          active_reg;
    logic [NC_W-1:0]     nc_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [DLY_AW-1:0]   cnt_reg;
    logic [1:0]          j_reg;
    logic [2:0]          sub_reg;
    logic [DI_W-1:0]     didx_reg;
    logic signed [15:0]  x_reg;

    logic signed [23:0]      coef_reg [NCOEF];
    logic signed [STATE_W-1:0] zr_reg [ORDER];
    logic signed [STATE_W-1:0] zi_reg [ORDER];
    logic signed [STATE_W-1:0] yr_reg, yi_reg;
    logic signed [ACC_W-1:0] accr_reg, acci_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [63:0]             v_reg;
    logic signed [31:0]      resr_reg;
    logic signed [31:0]      resi_reg;

    logic signed [23:0]  gain_reg [NUM_CH];
    logic [DI_W-1:0]     dlen_reg [NUM_CH];
    logic [FS_DEPTH-1:0] fs_valid_reg;
    logic                fs_vq_reg;

    logic                m_tvalid_reg;
    logic [71:0]         out_data_reg;
    logic                out_last_reg;

    logic                fs_we, cf_we, dl_we, load_out;
    logic [FS_AW-1:0]    fs_waddr, fs_raddr;
    logic [STATE_W-1:0]  fs_wdata, fs_rdata;
    logic [CF_AW-1:0]    cf_waddr, cf_raddr;
    logic [23:0]         cf_rdata;
    logic [DLY_AW-1:0]   dl_waddr, dl_raddr;
    logic [63:0]         dl_wdata, dl_rdata;

    logic [5:0]          in_channel;
    logic [3:0]          in_slot;
    logic signed [23:0]  in_lv;
    logic signed [15:0]  in_sample;
    logic                in_ch_ok;
    logic [NC_W-1:0]     nc_eff;
    logic                accept;
    logic [3:0]          lidx;
    logic [3:0]          cidx;
    logic                last_sub;
    logic [DI_W-1:0]     d_cur;
    logic [63:0]         new_dv;
    logic signed [23:0]  opa;
    logic signed [STATE_W-1:0] opb;
    logic signed [PROD_W-1:0] term;
    logic signed [ACC_W-1:0] accr_next, acci_next;
    logic signed [ACC_W-1:0] zr_up, zi_up;
    logic                out_free;
    logic                ch_is_last;

    assign in_channel = s_tdata[5:0];
    assign in_slot    = s_tdata[9:6];
    assign in_lv      = s_tdata[33:10];
    assign in_sample  = s_tdata[49:34];
    assign in_ch_ok   = {1'b0, in_channel} < 7'(NUM_CH);
    assign nc_eff     = (active_reg > 7'(NUM_CH)) ? NC_W'(NUM_CH) : NC_W'(active_reg);
    assign accept     = s_tvalid && s_tready;
    assign lidx       = cnt_reg[3:0] - 4'd1;
    assign last_sub   = (j_reg == 2'd3) ? (sub_reg == 3'd3) : (sub_reg == 3'd5);
    assign d_cur      = dlen_reg[ch_reg];
    assign new_dv     = {32'(yi_reg >>> 8), 32'(yr_reg >>> 8)};
    assign out_free   = !m_tvalid_reg || m_tready;
    assign ch_is_last = NC_W'(ch_reg) + NC_W'(1) == nc_reg;

    always_comb
    begin
        case (sub_reg)
            3'd0, 3'd2: cidx = 4'(2 * NB) + {1'b0, j_reg, 1'b0};
            3'd1, 3'd3: cidx = 4'(2 * NB + 1) + {1'b0, j_reg, 1'b0};
            3'd4:       cidx = {1'b0, j_reg, 1'b0};
            default:    cidx = {1'b0, j_reg, 1'b1};
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_GMUL)
        begin
            opa = gain_reg[ch_reg];
            opb = sub_reg[0] ? STATE_W'($signed(v_reg[63:32])) : STATE_W'($signed(v_reg[31:0]));
        end
        else
        begin
            opa = coef_reg[cidx];
            case (sub_reg)
                3'd0, 3'd3: opb = yr_reg;
                3'd1, 3'd2: opb = yi_reg;
                default:    opb = STATE_W'(x_reg);
            endcase
        end
    end

    always_comb
    begin
        term = (sub_reg >= 3'd4) ? (prod_reg >>> 11) : (prod_reg >>> 20);
        accr_next = accr_reg;
        acci_next = acci_reg;
        case (sub_reg)
            3'd0:    accr_next = accr_reg - ACC_W'(term);
            3'd1:    accr_next = accr_reg + ACC_W'(term);
            3'd2:    acci_next = acci_reg - ACC_W'(term);
            3'd3:    acci_next = acci_reg - ACC_W'(term);
            3'd4:    accr_next = accr_reg + ACC_W'(term);
            default: acci_next = acci_reg + ACC_W'(term);
        endcase
        zr_up = (j_reg == 2'd3) ? '0 : ACC_W'(zr_reg[j_reg + 2'd1]);
        zi_up = (j_reg == 2'd3) ? '0 : ACC_W'(zi_reg[j_reg + 2'd1]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == DLY_AW'(DLY_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept && s_tuser == OP_SAMPLE && nc_eff != '0)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (cnt_reg == DLY_AW'(NCOEF))
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (last_sub && j_reg == 2'd3)
                    state_next = ST_WB;
                else
                    state_next = ST_MUL;
            end
            ST_WB:
            begin
                if (cnt_reg[2:0] == 3'd7)
                    state_next = ST_DSET;
            end
            ST_DSET:
                state_next = (d_cur == '0) ? ST_GMUL : ST_DLY;
            ST_DLY:
            begin
                if (didx_reg == DI_W'(1))
                    state_next = ST_DLAST;
            end
            ST_DLAST:
                state_next = ST_GMUL;
            ST_GMUL:
                state_next = ST_GACC;
            ST_GACC:
                state_next = sub_reg[0] ? ST_OUT : ST_GMUL;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ch_is_last ? ST_IDLE : ST_LOAD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        fs_we    = 1'b0;
        fs_waddr = {ch_reg, cnt_reg[2:0]};
        fs_wdata = cnt_reg[2] ? zi_reg[cnt_reg[1:0]] : zr_reg[cnt_reg[1:0]];
        fs_raddr = {ch_reg, cnt_reg[2:0]};
        cf_we    = 1'b0;
        cf_waddr = CF_AW'(in_channel[CH_W-1:0]) * CF_AW'(NCOEF) + CF_AW'(in_slot);
        cf_raddr = CF_AW'(ch_reg) * CF_AW'(NCOEF) + CF_AW'(cnt_reg[3:0]);
        dl_we    = 1'b0;
        dl_waddr = {ch_reg, didx_reg};
        dl_wdata = dl_rdata;
        dl_raddr = {ch_reg, didx_reg - DI_W'(2)};
        load_out = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                dl_we    = 1'b1;
                dl_waddr = cnt_reg;
                dl_wdata = '0;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cf_we    = s_tvalid && s_tuser == OP_COEF && in_ch_ok
                           && in_slot < 4'(NCOEF);
            end
            ST_WB:
                fs_we = 1'b1;
            ST_DSET:
            begin
                dl_raddr = {ch_reg, d_cur - DI_W'(1)};
                if (d_cur == '0)
                begin
                    dl_we    = 1'b1;
                    dl_waddr = {ch_reg, DI_W'(0)};
                    dl_wdata = new_dv;
                end
            end
            ST_DLY:
                dl_we = 1'b1;
            ST_DLAST:
            begin
                dl_we    = 1'b1;
                dl_waddr = {ch_reg, DI_W'(0)};
                dl_wdata = new_dv;
            end
            ST_OUT:
                load_out = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            active_reg   <= 7'd32;
            cnt_reg      <= '0;
            fs_valid_reg <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
                dlen_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
                active_reg <= cfg_wdata;
            if (fs_we)
                fs_valid_reg[fs_waddr] <= 1'b1;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (state_reg == ST_IDLE && accept && s_tuser == OP_DELAY && in_ch_ok)
            begin
                if (in_lv < 0)
                    dlen_reg[in_channel[CH_W-1:0]] <= '0;
                else if (in_lv > 24'(MAX_DELAY - 1))
                    dlen_reg[in_channel[CH_W-1:0]] <= DI_W'(MAX_DELAY - 1);
                else
                    dlen_reg[in_channel[CH_W-1:0]] <= DI_W'(in_lv);
            end
            case (state_reg)
                ST_CLEAR, ST_LOAD, ST_WB:
                    cnt_reg <= (state_next == state_reg) ? cnt_reg + DLY_AW'(1) : '0;
                ST_OUT:
                    cnt_reg <= '0;
                default:
                    cnt_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        fs_vq_reg <= fs_valid_reg[fs_raddr];
        if (state_reg == ST_IDLE && accept)
        begin
            x_reg  <= in_sample;
            nc_reg <= nc_eff;
            ch_reg <= '0;
            if (s_tuser == OP_GAIN && in_ch_ok)
                gain_reg[in_channel[CH_W-1:0]] <= in_lv;
        end
        case (state_reg)
            ST_LOAD:
            begin
                if (cnt_reg != '0)
                begin
                    coef_reg[lidx] <= cf_rdata;
                    if (lidx < 4'd8)
                    begin
                        if (lidx[2])
                            zi_reg[lidx[1:0]] <= fs_vq_reg ? fs_rdata : '0;
                        else
                            zr_reg[lidx[1:0]] <= fs_vq_reg ? fs_rdata : '0;
                        if (lidx == 4'd0)
                            yr_reg <= fs_vq_reg ? fs_rdata : '0;
                        if (lidx == 4'd4)
                            yi_reg <= fs_vq_reg ? fs_rdata : '0;
                    end
                end
                j_reg    <= '0;
                sub_reg  <= '0;
                accr_reg <= '0;
                acci_reg <= '0;
            end
            ST_MUL, ST_GMUL:
                prod_reg <= opa * opb;
            ST_ACC:
            begin
                if (last_sub)
                begin
                    zr_reg[j_reg] <= sat40(accr_next + zr_up);
                    zi_reg[j_reg] <= sat40(acci_next + zi_up);
                    accr_reg      <= '0;
                    acci_reg      <= '0;
                    sub_reg       <= '0;
                    j_reg         <= j_reg + 2'd1;
                end
                else
                begin
                    accr_reg <= accr_next;
                    acci_reg <= acci_next;
                    sub_reg  <= sub_reg + 3'd1;
                end
            end
            ST_DSET:
            begin
                didx_reg <= d_cur;
                sub_reg  <= '0;
                if (d_cur == '0)
                    v_reg <= new_dv;
            end
            ST_DLY:
            begin
                if (didx_reg == d_cur)
                    v_reg <= dl_rdata;
                didx_reg <= didx_reg - DI_W'(1);
            end
            ST_GACC:
            begin
                if (sub_reg[0])
                    resi_reg <= sat32(prod_reg >>> 20);
                else
                    resr_reg <= sat32(prod_reg >>> 20);
                sub_reg <= sub_reg + 3'd1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg <= {2'd0, resi_reg, resr_reg, 6'(ch_reg)};
                    out_last_reg <= ch_is_last;
                    ch_reg       <= ch_reg + CH_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    cgab_ram #(.WIDTH(STATE_W), .DEPTH(FS_DEPTH)) u_fs_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    cgab_ram #(.WIDTH(24), .DEPTH(CF_DEPTH)) u_cf_ram (
        .clk   (clk),
        .we    (cf_we),
        .waddr (cf_waddr),
        .wdata (in_lv),
        .raddr (cf_raddr),
        .rdata (cf_rdata)
    );

    cgab_ram #(.WIDTH(64), .DEPTH(DLY_DEPTH)) u_dl_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready && !m_tvalid)
        else $error("transaction activity during the delay memory clear");

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DLY |-> dl_waddr != dl_raddr)
        else $error("delay shift reads the entry it writes");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !m_tvalid_reg || m_tready)
        else $error("pending result overwritten");

    a_result_follows_gain: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> $past(state_reg) == ST_GACC || $past(state_reg) == ST_OUT)
        else $error("result loaded without a gain step");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for the complex gammatone analysis filterbank core.
`timescale 1ns / 100ps

module tb;
    import cgab_pkg::*;

    typedef struct {
        logic [5:0]  chan;
        logic [31:0] re;
        logic [31:0] im;
        logic        last;
    } chan_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    int          active_cnt;
    int          coef_mem [NUM_CH][NCOEF];
    int          gain_mem [NUM_CH];
    int          dly_len [NUM_CH];
    longint      st_re [NUM_CH][ORDER];
    longint      st_im [NUM_CH][ORDER];
    int          line_re [NUM_CH][MAX_DELAY];
    int          line_im [NUM_CH][MAX_DELAY];

    chan_result_t expected_q[$];
    int          errors;
    int          cycles;
    bit          calm_tx;
    bit          calm_rx;
    bit          hold_go;
    bit          hold_on;

    complex_gammatone_analysis_bank_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp40(longint v);
        longint hi;
        hi = (longint'(1) <<< 39) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void run_filterbank(int x);
        int nc;
        longint yr, yi, ar, ai, fr, fi, nr, ni, vr, vi;
        int d;
        chan_result_t r;
        nc = (active_cnt > NUM_CH) ? NUM_CH : active_cnt;
        for (int k = 0; k < nc; k++)
        begin
            yr = st_re[k][0];
            yi = st_im[k][0];
            for (int j = 0; j < ORDER; j++)
            begin
                ar = coef_mem[k][2 * NB + 2 * j];
                ai = coef_mem[k][2 * NB + 2 * j + 1];
                fr = ((ar * yr) >>> 20) - ((ai * yi) >>> 20);
                fi = ((ar * yi) >>> 20) + ((ai * yr) >>> 20);
                nr = -fr;
                ni = -fi;
                if (j < NB)
                begin
                    nr += ((longint'(coef_mem[k][2 * j]) * x) >>> 11) + st_re[k][j + 1];
                    ni += ((longint'(coef_mem[k][2 * j + 1]) * x) >>> 11) + st_im[k][j + 1];
                end
                st_re[k][j] = clamp40(nr);
                st_im[k][j] = clamp40(ni);
            end
            d = dly_len[k];
            for (int i = d; i > 0; i--)
            begin
                line_re[k][i] = line_re[k][i - 1];
                line_im[k][i] = line_im[k][i - 1];
            end
            line_re[k][0] = int'(yr >>> 8);
            line_im[k][0] = int'(yi >>> 8);
            vr = clamp32((longint'(line_re[k][d]) * gain_mem[k]) >>> 20);
            vi = clamp32((longint'(line_im[k][d]) * gain_mem[k]) >>> 20);
            r.chan = k[5:0];
            r.re = vr[31:0];
            r.im = vi[31:0];
            r.last = (k + 1 == nc);
            expected_q.push_back(r);
        end
    endfunction

    function automatic void apply_item(logic [1:0] op, int ch, int slot, int lv, int x);
        if (op == OP_SAMPLE)
        begin
            run_filterbank(x);
            return;
        end
        if (ch >= NUM_CH)
            return;
        if (op == OP_COEF)
        begin
            if (slot < NCOEF)
                coef_mem[ch][slot] = lv;
        end
        else if (op == OP_DELAY)
            dly_len[ch] = (lv < 0) ? 0 : ((lv > MAX_DELAY - 1) ? MAX_DELAY - 1 : lv);
        else
            gain_mem[ch] = lv;
    endfunction

    task automatic send_item(logic [1:0] op, int ch, int slot, int lv, int x);
        while (!calm_tx && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'b0, x[15:0], lv[23:0], slot[3:0], ch[5:0]};
        do
            @(posedge clk);
        while (!s_tready);
        apply_item(op, ch, slot, lv, x);
    endtask

    task automatic send_sample(int x);
        send_item(OP_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 15),
                  $urandom_range(0, 24'hFFFFFF), x);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (NUM_CH * (80 + MAX_DELAY) + 200) @(posedge clk);
    endtask

    task automatic write_active(int v);
        cfg_wen <= 1'b1;
        cfg_wdata <= v[6:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
        active_cnt = v;
    endtask

    function automatic int small_coef();
        return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    function automatic int full_value();
        int v;
        v = $urandom_range(0, 24'hFFFFFF);
        return (v ^ 24'h800000) - 24'h800000;
    endfunction

    always @(posedge clk)
    begin
        chan_result_t e;
        if (m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata[5:0] !== e.chan)
                begin
                    $display("%0t: channel expected %0d actual %0d", $time, e.chan, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[37:6] !== e.re)
                begin
                    $display("%0t: ch %0d real expected %h actual %h", $time, e.chan, e.re,
                             m_tdata[37:6]);
                    errors++;
                end
                if (m_tdata[69:38] !== e.im)
                begin
                    $display("%0t: ch %0d imag expected %h actual %h", $time, e.chan, e.im,
                             m_tdata[69:38]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $display("%0t: ch %0d last expected %b actual %b", $time, e.chan, e.last,
                             m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_on)
            m_tready <= 1'b0;
        else if (calm_rx)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 11);
    end

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (6000) @(posedge clk);
        hold_on = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 4000000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_load_all();
        for (int k = 0; k < NUM_CH; k++)
        begin
            for (int s = 0; s < NCOEF; s++)
                send_item(OP_COEF, k, s, (s < 2 * NB) ? small_coef() * 4 : small_coef(), 0);
            send_item(OP_GAIN, k, 0, 1 << 20, 0);
        end
    endtask

    task automatic test_extremes();
        send_sample(32767);
        send_sample(-32768);
        send_sample(0);
        send_item(OP_GAIN, 0, 0, 8388607, 0);
        send_item(OP_GAIN, 1, 0, -8388608, 0);
        send_item(OP_COEF, 2, 0, 8388607, 0);
        send_item(OP_COEF, 3, 13, -8388608, 0);
        send_item(OP_COEF, 4, 14, 8388607, 0);
        send_item(OP_COEF, 5, 15, -1, 0);
        send_item(OP_COEF, 63, 0, 12345, 0);
        send_item(OP_GAIN, 40, 0, 7, 0);
        send_item(OP_DELAY, 33, 0, 5, 0);
        send_item(OP_DELAY, 6, 0, -8388608, 0);
        send_item(OP_DELAY, 7, 0, 8388607, 0);
        send_item(OP_DELAY, 8, 0, 3, 0);
        send_sample(32767);
        send_sample(-32768);
        send_item(OP_DELAY, 8, 0, 10, 0);
        send_item(OP_DELAY, 7, 0, 1, 0);
        send_sample(-1);
        send_sample(12000);
        wait_drained();
    endtask

    task automatic test_active_settings();
        int settings[4] = '{0, 1, 127, 64};
        foreach (settings[i])
        begin
            write_active(settings[i]);
            send_sample(-32768);
            send_sample(32767);
            send_sample(full_value() >>> 8);
            wait_drained();
        end
    endtask

    task automatic random_item();
        int pick;
        int ch;
        pick = $urandom_range(0, 99);
        ch = $urandom_range(0, NUM_CH - 1);
        if (pick < 76)
            send_sample(full_value() >>> 8);
        else if (pick < 86)
            send_item(OP_COEF, ch, $urandom_range(0, NCOEF - 1),
                      ($urandom_range(0, 3) == 0) ? full_value() : small_coef(), 0);
        else if (pick < 92)
            send_item(OP_DELAY, ch, 0,
                      ($urandom_range(0, 5) == 0) ? full_value() : $urandom_range(0, 8), 0);
        else if (pick < 97)
            send_item(OP_GAIN, ch, 0,
                      ($urandom_range(0, 3) == 0) ? full_value() : small_coef() * 16, 0);
        else
            send_item($urandom_range(1, 3), $urandom_range(NUM_CH, 63), $urandom_range(0, 15),
                      full_value(), full_value() >>> 8);
    endtask

    task automatic test_random();
        write_active(5);
        for (int i = 0; i < 16; i++)
            random_item();
        calm_tx = 1'b1;
        calm_rx = 1'b1;
        for (int i = 0; i < 6; i++)
            random_item();
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        wait_drained();
        write_active(12);
        for (int i = 0; i < 6; i++)
            random_item();
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_active(3);
        hold_go = 1'b1;
        calm_tx = 1'b1;
        for (int i = 0; i < 10; i++)
            send_sample(full_value() >>> 8);
        calm_tx = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_SAMPLE;
        m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        hold_go = 1'b0;
        hold_on = 1'b0;
        active_cnt = 32;
        for (int k = 0; k < NUM_CH; k++)
        begin
            dly_len[k] = 0;
            gain_mem[k] = 0;
            for (int s = 0; s < NCOEF; s++)
                coef_mem[k][s] = 0;
            for (int j = 0; j < ORDER; j++)
            begin
                st_re[k][j] = 0;
                st_im[k][j] = 0;
            end
            for (int i = 0; i < MAX_DELAY; i++)
            begin
                line_re[k][i] = 0;
                line_im[k][i] = 0;
            end
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_all();
        test_extremes();
        test_active_settings();
        test_random();
        test_backpressure();

        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
